// ----- design/swrms_pkg.sv -----
// Shared types and constants for the sliding-window RMS and power accumulator.
// No dependencies; the channel interfaces and the top level use this package.
package swrms_pkg;

	localparam int NCH    = 6;
	localparam int NPH    = 3;
	localparam int SMP_W  = 12;
	localparam int WORD_W = 16;
	localparam int SQ_W   = 38;
	localparam int PW_W   = 39;
	localparam int PROD_W = 32;
	localparam int IDX_W  = 2;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_OSR    = 2'd0;
	localparam logic [IDX_W-1:0] REG_TRIM   = 2'd1;
	localparam logic [IDX_W-1:0] REG_PERIOD = 2'd2;

	typedef logic [NCH-1:0][WORD_W-1:0] row_t;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_CMUL, ST_CACC, ST_DRD, ST_DMUL, ST_DACC,
		ST_RRD, ST_RACC, ST_DLD, ST_DWAIT, ST_PRESET, ST_DONE
	} st_t;

endpackage

// ----- design/swrms_smp_if.sv -----
// Sample channel: six 12-bit ADC samples under a valid/ready handshake.
// Depends on swrms_pkg.
interface swrms_smp_if;
	logic valid;
	logic ready;
	logic [swrms_pkg::SMP_W-1:0] volt_a;
	logic [swrms_pkg::SMP_W-1:0] curr_a;
	logic [swrms_pkg::SMP_W-1:0] volt_b;
	logic [swrms_pkg::SMP_W-1:0] curr_b;
	logic [swrms_pkg::SMP_W-1:0] volt_c;
	logic [swrms_pkg::SMP_W-1:0] curr_c;

	modport source (output valid, volt_a, curr_a, volt_b, curr_b, volt_c, curr_c,
		input ready);
	modport sink (input valid, volt_a, curr_a, volt_b, curr_b, volt_c, curr_c,
		output ready);
endinterface

// ----- design/swrms_res_if.sv -----
// Result channel: windowed square and power sums plus status flags.
// Depends on swrms_pkg.
interface swrms_res_if;
	logic valid;
	logic ready;
	logic [swrms_pkg::SQ_W-1:0] sq_volt_a;
	logic [swrms_pkg::SQ_W-1:0] sq_curr_a;
	logic [swrms_pkg::SQ_W-1:0] sq_volt_b;
	logic [swrms_pkg::SQ_W-1:0] sq_curr_b;
	logic [swrms_pkg::SQ_W-1:0] sq_volt_c;
	logic [swrms_pkg::SQ_W-1:0] sq_curr_c;
	logic signed [swrms_pkg::PW_W-1:0] power_a;
	logic signed [swrms_pkg::PW_W-1:0] power_b;
	logic signed [swrms_pkg::PW_W-1:0] power_c;
	logic slot_closed;
	logic recalibrated;

	modport source (output valid, sq_volt_a, sq_curr_a, sq_volt_b, sq_curr_b,
		sq_volt_c, sq_curr_c, power_a, power_b, power_c, slot_closed, recalibrated,
		input ready);
	modport sink (input valid, sq_volt_a, sq_curr_a, sq_volt_b, sq_curr_b,
		sq_volt_c, sq_curr_c, power_a, power_b, power_c, slot_closed, recalibrated,
		output ready);
endinterface

// ----- design/swrms_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Standalone; used by the top level for offset recalibration.
module swrms_div #(
	parameter int W  = 27,
	parameter int DW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] dvd,
	input  logic [DW-1:0]       dsr,
	output logic                done,
	output logic signed [W-1:0] quo
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  mag_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fits;

	// One restoring step
	assign trial = {rem_q, mag_q[W-1]};
	assign fits  = trial >= {1'b0, dsr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q  <= cnt_q - 1'b1;
				busy_q <= (cnt_q != CW'(1));
				done_q <= (cnt_q == CW'(1));
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// Shift dividend magnitude, collect quotient bits in its place
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dvd[W-1];
			mag_q <= dvd[W-1] ? W'(-dvd) : W'(dvd);
			rem_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[W-2:0], fits};
			rem_q <= fits ? DW'(trial - {1'b0, dsr}) : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -signed'(mag_q) : signed'(mag_q);

endmodule

// ----- design/sliding_window_rms_power_accumulator_top.sv -----
// Channel   Dir  Handshake      Payload
// sample    in   valid/ready    volt_a..curr_c, 12 bits each
// result    out  valid/ready    six 38-bit square sums, three 39-bit power sums, flags
// cfg       in   cfg_we         cfg_idx selects register, cfg_wdata 16 bits
//
// An item that does not close a slot passes IDLE and DONE; closing a slot runs
// CMUL, CACC, DRD, DMUL, DACC, PRESET and DONE. A recalibration replaces the drop
// (DRD to DACC) with an RRD/RACC pair per swept slot and six divisions (DLD, DWAIT).
// After reset a clearing pass writes RING_SLOTS rows (one per cycle) before the
// first item is taken.
// A result waits in its output register; a later item still runs, then waits in DONE.
// Depends on swrms_pkg, swrms_smp_if, swrms_res_if, swrms_div.
module sliding_window_rms_power_accumulator_top #(
	parameter int RING_SLOTS = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	swrms_smp_if.sink                     sample,
	swrms_res_if.source                   result,
	input  logic                          cfg_we,
	input  logic [swrms_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [swrms_pkg::WORD_W-1:0]  cfg_wdata
);

	import swrms_pkg::*;

	localparam int SW    = $clog2(RING_SLOTS);
	localparam int TOT_W = WORD_W + SW + 1;
	localparam logic [SW-1:0] LAST = SW'(RING_SLOTS - 1);

	st_t st_q, st_d;

	// Configuration
	logic [3:0]  osr_q;
	logic [6:0]  trim_q;
	logic [15:0] per_q;

	// Block state
	logic [SW-1:0]  ws_q;
	logic [3:0]     idx_q;
	logic [15:0]    wrap_q;
	logic [SW-1:0]  i_q;
	logic [2:0]     ch_q;
	row_t           cur_q;
	row_t           off_q;
	logic [NCH-1:0][SQ_W-1:0] sq_q;
	logic [NPH-1:0][PW_W-1:0] pw_q;
	logic           closed_q;
	logic           recal_q;
	logic [NCH-1:0][SMP_W-1:0] smp_q;
	logic signed [NCH-1:0][TOT_W-1:0] tot_q;
	logic [NCH-1:0][PROD_W-1:0] sq_s1;
	logic [NPH-1:0][PROD_W-1:0] pw_s1;
	logic           res_valid_q;

	// Slot memory
	row_t           mem [RING_SLOTS];
	row_t           rdata_q;
	logic           mem_we, mem_re;
	logic [SW-1:0]  mem_waddr, mem_raddr;
	row_t           mem_wdata;

	// Derived controls
	logic [3:0]     cnt_eff;
	logic [15:0]    per_eff;
	logic [SW-1:0]  teff;
	logic [SW:0]    drop_sum;
	logic [SW-1:0]  drop_addr;
	logic [SW:0]    win_n;
	logic [15:0]    wrap_inc;
	logic           close_now, recal_now, out_free, div_start, div_done;
	logic signed [TOT_W-1:0] div_quo;
	row_t           msrc;
	logic [NCH-1:0][SMP_W-1:0] smp_in;

	assign cnt_eff   = (osr_q == 4'd0) ? 4'd1 : osr_q;
	assign per_eff   = (per_q == 16'd0) ? 16'd1 : per_q;
	assign teff      = (int'(trim_q) >= RING_SLOTS) ? LAST : SW'(trim_q);
	assign drop_sum  = {1'b0, ws_q} + {1'b0, teff};
	assign drop_addr = (drop_sum >= (SW+1)'(RING_SLOTS)) ?
		SW'(drop_sum - (SW+1)'(RING_SLOTS)) : drop_sum[SW-1:0];
	assign win_n     = (SW+1)'(RING_SLOTS) - {1'b0, teff};
	assign wrap_inc  = wrap_q + 16'd1;
	assign close_now = idx_q >= cnt_eff;
	assign recal_now = (ws_q == LAST) && (wrap_inc >= per_eff);
	assign out_free  = !res_valid_q || result.ready;
	assign smp_in    = {sample.curr_c, sample.volt_c, sample.curr_b, sample.volt_b,
		sample.curr_a, sample.volt_a};
	assign sample.ready = (st_q == ST_IDLE);

	// Hold state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_CLR;
		else st_q <= st_d;
	end

	// Next state and memory strobes
	always_comb begin
		st_d      = st_q;
		mem_we    = 1'b0;
		mem_waddr = i_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = i_q;
		div_start = 1'b0;
		case (st_q)
			ST_CLR: begin
				mem_we = 1'b1;
				if (i_q == LAST) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (sample.valid) st_d = close_now ? ST_CMUL : ST_DONE;
			end
			ST_CMUL: begin
				mem_we    = 1'b1;
				mem_waddr = ws_q;
				mem_wdata = cur_q;
				st_d      = ST_CACC;
			end
			ST_CACC: st_d = recal_now ? ST_RRD : ST_DRD;
			ST_DRD: begin
				mem_re    = 1'b1;
				mem_raddr = drop_addr;
				st_d      = ST_DMUL;
			end
			ST_DMUL: st_d = ST_DACC;
			ST_DACC: st_d = ST_PRESET;
			ST_RRD: begin
				mem_re = 1'b1;
				st_d   = ST_RACC;
			end
			ST_RACC: begin
				mem_we = 1'b1;
				st_d   = (i_q == LAST) ? ST_DLD : ST_RRD;
			end
			ST_DLD: begin
				div_start = 1'b1;
				st_d      = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (div_done) st_d = (ch_q == 3'(NCH - 1)) ? ST_PRESET : ST_DLD;
			end
			ST_PRESET: st_d = ST_DONE;
			ST_DONE: begin
				if (out_free) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// Slot memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osr_q  <= 4'd8;
			trim_q <= 7'd1;
			per_q  <= 16'd128;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_OSR:    osr_q  <= cfg_wdata[3:0];
				REG_TRIM:   trim_q <= cfg_wdata[6:0];
				REG_PERIOD: per_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Squares and products of the closing or the dropped slot
	assign msrc = (st_q == ST_DMUL) ? rdata_q : cur_q;
	always_ff @(posedge clk) begin
		if (st_q == ST_CMUL || st_q == ST_DMUL) begin
			for (int k = 0; k < NCH; k++)
				sq_s1[k] <= PROD_W'(signed'(msrc[k]) * signed'(msrc[k]));
			for (int k = 0; k < NPH; k++)
				pw_s1[k] <= PROD_W'(signed'(msrc[2*k]) * signed'(msrc[2*k+1]));
		end
	end

	// Control and accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q     <= '0;
			idx_q    <= '0;
			wrap_q   <= '0;
			i_q      <= '0;
			ch_q     <= '0;
			cur_q    <= '0;
			off_q    <= '0;
			sq_q     <= '0;
			pw_q     <= '0;
			closed_q <= 1'b0;
			recal_q  <= 1'b0;
		end else begin
			case (st_q)
				ST_CLR: begin
					i_q <= (i_q == LAST) ? '0 : i_q + 1'b1;
				end
				ST_IDLE: begin
					if (sample.valid) begin
						closed_q <= close_now;
						recal_q  <= 1'b0;
						if (!close_now) begin
							for (int k = 0; k < NCH; k++)
								cur_q[k] <= cur_q[k] + WORD_W'(smp_in[k]);
							idx_q <= idx_q + 4'd1;
						end
					end
				end
				ST_CACC, ST_DACC: begin
					// Clear all sums on a recalibration, else add or drop the slot
					if (st_q == ST_CACC && recal_now) begin
						sq_q <= '0;
						pw_q <= '0;
					end else begin
						for (int k = 0; k < NCH; k++)
							sq_q[k] <= (st_q == ST_DACC) ? sq_q[k] - SQ_W'(sq_s1[k])
								: sq_q[k] + SQ_W'(sq_s1[k]);
						for (int k = 0; k < NPH; k++)
							pw_q[k] <= (st_q == ST_DACC)
								? pw_q[k] - {{(PW_W-PROD_W){pw_s1[k][PROD_W-1]}}, pw_s1[k]}
								: pw_q[k] + {{(PW_W-PROD_W){pw_s1[k][PROD_W-1]}}, pw_s1[k]};
					end
					if (st_q == ST_CACC) begin
						if (ws_q == LAST) begin
							ws_q   <= '0;
							wrap_q <= recal_now ? 16'd0 : wrap_inc;
						end else begin
							ws_q <= ws_q + 1'b1;
						end
						recal_q <= recal_now;
						if (recal_now) begin
							i_q  <= teff;
							ch_q <= '0;
						end
					end
				end
				ST_RACC: begin
					i_q <= (i_q == LAST) ? '0 : i_q + 1'b1;
				end
				ST_DWAIT: begin
					if (div_done) begin
						off_q[ch_q] <= off_q[ch_q] + div_quo[WORD_W-1:0];
						ch_q        <= ch_q + 3'd1;
					end
				end
				ST_PRESET: begin
					for (int k = 0; k < NCH; k++)
						cur_q[k] <= WORD_W'(smp_q[k]) - off_q[k];
					idx_q <= 4'd1;
				end
				default: ;
			endcase
		end
	end

	// Latch samples and sweep totals
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && sample.valid) smp_q <= smp_in;
		if (st_q == ST_CACC) tot_q <= '0;
		if (st_q == ST_RACC) begin
			for (int k = 0; k < NCH; k++)
				tot_q[k] <= tot_q[k] + {{(TOT_W-WORD_W){rdata_q[k][WORD_W-1]}}, rdata_q[k]};
		end
	end

	swrms_div #(.W(TOT_W), .DW(SW + 1)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (tot_q[ch_q]),
		.dsr    (win_n),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (st_q == ST_DONE && out_free) res_valid_q <= 1'b1;
		else if (result.ready) res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_DONE && out_free) begin
			result.sq_volt_a    <= sq_q[0];
			result.sq_curr_a    <= sq_q[1];
			result.sq_volt_b    <= sq_q[2];
			result.sq_curr_b    <= sq_q[3];
			result.sq_volt_c    <= sq_q[4];
			result.sq_curr_c    <= sq_q[5];
			result.power_a      <= signed'(pw_q[0]);
			result.power_b      <= signed'(pw_q[1]);
			result.power_c      <= signed'(pw_q[2]);
			result.slot_closed  <= closed_q;
			result.recalibrated <= recal_q;
		end
	end

	assign result.valid = res_valid_q;

endmodule

// ----- bench/swrms_checker.sv -----
// Checker for the sliding-window RMS and power accumulator: snoops the config
// port and both channels, predicts every result and compares it field by field.
// Depends on swrms_pkg, swrms_smp_if, swrms_res_if.
module swrms_checker #(
	parameter int RING_SLOTS = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	swrms_smp_if                          smp,
	swrms_res_if                          res,
	input  logic                          cfg_we,
	input  logic [swrms_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [swrms_pkg::WORD_W-1:0]  cfg_wdata,
	output int                            pending,
	output int                            errors
);
	import swrms_pkg::*;

	typedef struct packed {
		logic [NCH-1:0][SQ_W-1:0] sq;
		logic [NPH-1:0][PW_W-1:0] pw;
		logic                     closed;
		logic                     recal;
	} sums_t;

	// Mirror of the block's registers and state
	logic [3:0]        osr;
	logic [6:0]        trim;
	logic [15:0]       period;
	logic [WORD_W-1:0] ring [RING_SLOTS][NCH];
	logic [WORD_W-1:0] offs [NCH];
	logic [SQ_W-1:0]   sq_acc [NCH];
	logic [PW_W-1:0]   pw_acc [NPH];
	int                wr_slot;
	int                os_idx;
	logic [15:0]       wraps;
	sums_t             expected_q [$];

	function automatic longint s16(logic [WORD_W-1:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic int trim_eff();
		return (int'(trim) >= RING_SLOTS) ? RING_SLOTS - 1 : int'(trim);
	endfunction

	// Add or remove one slot's squares and products
	function automatic void fold_slot(int s, bit add);
		longint v;
		for (int k = 0; k < NCH; k++) begin
			v = s16(ring[s][k]) * s16(ring[s][k]);
			sq_acc[k] = add ? sq_acc[k] + SQ_W'(v) : sq_acc[k] - SQ_W'(v);
		end
		for (int k = 0; k < NPH; k++) begin
			v = s16(ring[s][2*k]) * s16(ring[s][2*k+1]);
			pw_acc[k] = add ? pw_acc[k] + PW_W'(v) : pw_acc[k] - PW_W'(v);
		end
	endfunction

	function automatic void preset_slot(int s);
		for (int k = 0; k < NCH; k++) ring[s][k] = -offs[k];
	endfunction

	// Fold window means into offsets, clear window slots and sums, preset slot 0
	function automatic void recal_offsets();
		longint total [NCH];
		longint n;
		int t;
		t = trim_eff();
		n = RING_SLOTS - t;
		for (int k = 0; k < NCH; k++) total[k] = 0;
		for (int i = t; i < RING_SLOTS; i++)
			for (int k = 0; k < NCH; k++) begin
				total[k] += s16(ring[i][k]);
				ring[i][k] = '0;
			end
		for (int k = 0; k < NCH; k++) begin
			offs[k] = offs[k] + WORD_W'(total[k] / n);
			sq_acc[k] = '0;
		end
		for (int k = 0; k < NPH; k++) pw_acc[k] = '0;
		preset_slot(0);
	endfunction

	function automatic sums_t predict_sums(logic [NCH-1:0][SMP_W-1:0] smpl);
		sums_t r;
		int cnt, per;
		cnt = (osr == 0) ? 1 : int'(osr);
		per = (period == 0) ? 1 : int'(period);
		r.closed = 1'b0;
		r.recal = 1'b0;
		if (os_idx >= cnt) begin
			r.closed = 1'b1;
			os_idx = 0;
			fold_slot(wr_slot, 1'b1);
			wr_slot++;
			if (wr_slot >= RING_SLOTS) begin
				wr_slot = 0;
				wraps = wraps + 16'd1;
				if (int'(wraps) >= per) begin
					wraps = '0;
					r.recal = 1'b1;
					recal_offsets();
				end
			end
			if (!r.recal) fold_slot((wr_slot + trim_eff()) % RING_SLOTS, 1'b0);
			preset_slot(wr_slot);
		end
		for (int k = 0; k < NCH; k++)
			ring[wr_slot][k] = ring[wr_slot][k] + WORD_W'(smpl[k]);
		os_idx = (os_idx + 1) & 15;
		for (int k = 0; k < NCH; k++) r.sq[k] = sq_acc[k];
		for (int k = 0; k < NPH; k++) r.pw[k] = pw_acc[k];
		return r;
	endfunction

	task automatic check_field(string name, logic [PW_W-1:0] exp_v, logic [PW_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// Snoop config, predict on each accepted sample item, compare on each result item
	always @(posedge clk or negedge arst_n) begin
		sums_t e;
		logic [NCH-1:0][SMP_W-1:0] smpl;
		if (!arst_n) begin
			osr = 4'd8;
			trim = 7'd1;
			period = 16'd128;
			for (int i = 0; i < RING_SLOTS; i++)
				for (int k = 0; k < NCH; k++) ring[i][k] = '0;
			for (int k = 0; k < NCH; k++) begin
				offs[k] = '0;
				sq_acc[k] = '0;
			end
			for (int k = 0; k < NPH; k++) pw_acc[k] = '0;
			wr_slot = 0;
			os_idx = 0;
			wraps = '0;
			expected_q.delete();
			pending <= 0;
			errors <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_OSR:    osr = cfg_wdata[3:0];
					REG_TRIM:   trim = cfg_wdata[6:0];
					REG_PERIOD: period = cfg_wdata;
					default: ;
				endcase
			end
			if (smp.valid && smp.ready) begin
				smpl = {smp.curr_c, smp.volt_c, smp.curr_b, smp.volt_b, smp.curr_a, smp.volt_a};
				expected_q.push_back(predict_sums(smpl));
			end
			if (res.valid && res.ready) begin
				if (expected_q.size() == 0) begin
					$error("result item with no expectation waiting");
					errors++;
				end else begin
					e = expected_q.pop_front();
					check_field("sq_volt_a", PW_W'(e.sq[0]), PW_W'(res.sq_volt_a));
					check_field("sq_curr_a", PW_W'(e.sq[1]), PW_W'(res.sq_curr_a));
					check_field("sq_volt_b", PW_W'(e.sq[2]), PW_W'(res.sq_volt_b));
					check_field("sq_curr_b", PW_W'(e.sq[3]), PW_W'(res.sq_curr_b));
					check_field("sq_volt_c", PW_W'(e.sq[4]), PW_W'(res.sq_volt_c));
					check_field("sq_curr_c", PW_W'(e.sq[5]), PW_W'(res.sq_curr_c));
					check_field("power_a", e.pw[0], res.power_a);
					check_field("power_b", e.pw[1], res.power_b);
					check_field("power_c", e.pw[2], res.power_c);
					check_field("slot_closed", PW_W'(e.closed), PW_W'(res.slot_closed));
					check_field("recalibrated", PW_W'(e.recal), PW_W'(res.recalibrated));
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

// ----- bench/tb.sv -----
// Testbench top: clock, reset, sample stimulus, result back-pressure, config
// phases and the verdict. Depends on swrms_pkg, both channel interfaces,
// swrms_checker and the accumulator top.
module tb;
	import swrms_pkg::*;

	localparam int LIMIT  = 600000;
	localparam int SETTLE = 900;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_idx;
	logic [WORD_W-1:0] cfg_wdata;
	int                pending;
	int                errors;
	int                cycles;
	bit                idle_on;
	bit                long_hold;

	swrms_smp_if smp ();
	swrms_res_if res ();

	sliding_window_rms_power_accumulator_top u_top (
		.clk(clk), .arst_n(arst_n), .sample(smp), .result(res),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	swrms_checker u_chk (
		.clk(clk), .arst_n(arst_n), .smp(smp), .res(res),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.pending(pending), .errors(errors)
	);

	always #4 clk = ~clk;

	// Abort on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Drive result ready: random stall bursts, one long hold on request
	initial begin
		int hold;
		hold = 0;
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				res.ready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 1'b0;
				res.ready <= 1'b1;
			end else if (hold > 0) begin
				hold--;
				res.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 17) - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// Offer one sample item, with an optional idle burst first
	task automatic send_sample(logic [NCH-1:0][SMP_W-1:0] v);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			smp.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		smp.valid  <= 1'b1;
		smp.volt_a <= v[0];
		smp.curr_a <= v[1];
		smp.volt_b <= v[2];
		smp.curr_b <= v[3];
		smp.volt_c <= v[4];
		smp.curr_c <= v[5];
		@(posedge clk);
		while (!smp.ready) @(posedge clk);
	endtask

	// Mostly mains-like waveforms around mid-scale, some full-range noise
	function automatic logic [NCH-1:0][SMP_W-1:0] rand_sample(int n);
		logic [NCH-1:0][SMP_W-1:0] v;
		int amp;
		for (int k = 0; k < NCH; k++) begin
			if ($urandom_range(0, 4) == 0) begin
				v[k] = SMP_W'($urandom);
			end else begin
				amp = $urandom_range(0, 2047);
				v[k] = ((n + k) % 16 < 8) ? SMP_W'(2048 + amp) : SMP_W'(2048 - amp);
			end
		end
		return v;
	endfunction

	task automatic run_random(int count);
		for (int n = 0; n < count; n++) send_sample(rand_sample(n));
		smp.valid <= 1'b0;
	endtask

	// Hold until all results are back and the block has settled
	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_regs(logic [WORD_W-1:0] o, logic [WORD_W-1:0] t, logic [WORD_W-1:0] p);
		write_cfg(REG_OSR, o);
		write_cfg(REG_TRIM, t);
		write_cfg(REG_PERIOD, p);
		@(posedge clk);
	endtask

	initial begin
		logic [NCH-1:0][SMP_W-1:0] v;
		clk = 1'b0;
		arst_n = 1'b0;
		cycles = 0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		idle_on = 1'b1;
		long_hold = 1'b0;
		smp.valid = 1'b0;
		smp.volt_a = '0;
		smp.curr_a = '0;
		smp.volt_b = '0;
		smp.curr_b = '0;
		smp.volt_c = '0;
		smp.curr_c = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes and bit patterns at reset settings
		for (int n = 0; n < 24; n++) begin
			case (n % 6)
				0: v = '0;
				1: v = '1;
				2: v = {NCH{12'hAAA}};
				3: v = {NCH{12'h555}};
				4: v = {12'hFFF, 12'h000, 12'h000, 12'hFFF, 12'hFFF, 12'h000};
				default: v = {12'h800, 12'h7FF, 12'h001, 12'hFFE, 12'h800, 12'h001};
			endcase
			send_sample(v);
		end
		smp.valid <= 1'b0;
		drain();

		// Fastest slots, full window, recalibrate every wrap
		set_regs(16'hFFF1, 16'hFF80, 16'd1);
		run_random(280);
		drain();

		// Zero count and period act as one, widest trim; long result stall here
		set_regs(16'd0, 16'd127, 16'd0);
		long_hold = 1'b1;
		run_random(200);
		drain();

		// Largest count, rare recalibration
		set_regs(16'd15, 16'd5, 16'hFFFF);
		run_random(80);
		drain();

		// Mid settings, then a final stretch with no idling
		set_regs(16'd2, 16'd64, 16'd2);
		run_random(140);
		idle_on = 1'b0;
		run_random(140);

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
